// ----- rtl/gmc_pkg.sv -----
`default_nettype none
package gmc_pkg;

	// mode codes, as reported on the result
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_IDLE         = 3'd0;
	localparam mode_t MODE_KEYBOARD     = 3'd1;
	localparam mode_t MODE_CURSOR_MOVE  = 3'd2;
	localparam mode_t MODE_CURSOR_CLICK = 3'd3;
	localparam mode_t MODE_MOUSE_MOVE   = 3'd4;
	localparam mode_t MODE_MOUSE_CLICK  = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 22;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MOUSE_ONLY      = 3'd0;
	localparam cfg_idx_t CFG_PINCH_GAP_LIMIT = 3'd1;
	localparam cfg_idx_t CFG_CLICK_SUM_LIMIT = 3'd2;
	localparam cfg_idx_t CFG_PINCH_FRAMES    = 3'd3;
	localparam cfg_idx_t CFG_IDLE_LIMIT_MS   = 3'd4;

	localparam int WINDOW_LEN_DEF = 10;
	localparam int HEIGHT_W = 16;
	localparam int RISE_W = HEIGHT_W + 1;
	localparam int ACCEL_W = HEIGHT_W + 2;
	localparam int LIMIT_W = 22;

	typedef struct packed {
		logic                        mouse_only;
		logic [15:0]                 pinch_gap_limit;
		logic signed [LIMIT_W-1:0]   click_sum_limit;
		logic [7:0]                  pinch_frames;
		logic [15:0]                 idle_limit_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mouse_only:      1'b0,
		pinch_gap_limit: 16'd300,
		click_sum_limit: -22'sd40,
		pinch_frames:    8'd30,
		idle_limit_ms:   16'd100
	};

	typedef struct packed {
		logic                        key_down;
		logic                        markers_ok;
		logic signed [HEIGHT_W-1:0]  tip_height;
		logic [15:0]                 finger_gap;
		logic [15:0]                 pointer_x;
		logic [15:0]                 pointer_y;
		logic                        button_down;
		logic [7:0]                  elapsed_ms;
	} frame_t;

	typedef struct packed {
		mode_t       mode;
		logic        mode_changed;
		logic        click_pulse;
		mode_t       left_mode;
		logic [15:0] left_mode_ms;
	} result_t;

	// mode tracker to window: run the click test on this frame
	typedef struct packed {
		logic                        update;
		logic signed [HEIGHT_W-1:0]  height;
	} win_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/gmc_window.sv -----
`default_nettype none
module gmc_window #(
	parameter int WINDOW_LEN = gmc_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire gmc_pkg::win_ctl_t                     ctl,
	input  wire logic signed [gmc_pkg::LIMIT_W-1:0]   limit,
	output logic                                       hit
);
	import gmc_pkg::*;

	localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = ACCEL_W + $clog2(WINDOW_LEN);
	localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

	logic signed [ACCEL_W-1:0]  win_q [WINDOW_LEN];
	logic [PTR_W-1:0]           pos_q;
	logic [FILL_W-1:0]          fill_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [HEIGHT_W-1:0] last_height_q;
	logic signed [RISE_W-1:0]   last_rise_q;

	logic signed [RISE_W-1:0]   rise;
	logic signed [ACCEL_W-1:0]  accel;
	logic signed [ACCEL_W-1:0]  oldest;
	logic signed [SUM_W-1:0]    sum_new;
	logic                       full;
	logic                       full_new;
	logic signed [CMP_W-1:0]    sum_cmp;
	logic signed [CMP_W-1:0]    limit_cmp;

	always_comb begin
		rise = {ctl.height[HEIGHT_W-1], ctl.height} - {last_height_q[HEIGHT_W-1], last_height_q};
		accel = {rise[RISE_W-1], rise} - {last_rise_q[RISE_W-1], last_rise_q};
		full = (fill_q == FILL_FULL);
		full_new = full || (fill_q == FILL_W'(WINDOW_LEN - 1));
		oldest = full ? win_q[pos_q] : '0;
		sum_new = sum_q + {{(SUM_W-ACCEL_W){accel[ACCEL_W-1]}}, accel}
			- {{(SUM_W-ACCEL_W){oldest[ACCEL_W-1]}}, oldest};
		sum_cmp = CMP_W'(sum_new);
		limit_cmp = CMP_W'(limit);
		hit = full_new && (sum_cmp < limit_cmp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			last_height_q <= '0;
			last_rise_q <= '0;
		end else if (ctl.update) begin
			pos_q <= (pos_q == PTR_LAST) ? '0 : pos_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			sum_q <= sum_new;
			last_height_q <= ctl.height;
			last_rise_q <= rise;
		end
	end

	// sample storage, no reset: only read once every slot has been written
	always_ff @(posedge clk) begin
		if (ctl.update) begin
			win_q[pos_q] <= accel;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/gmc_mode.sv -----
`default_nettype none
module gmc_mode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire gmc_pkg::frame_t    frame_s1,
	input  wire gmc_pkg::cfg_t      cfg,
	input  wire logic               click_hit,
	output gmc_pkg::win_ctl_t       win_ctl,
	output gmc_pkg::result_t        result_d
);
	import gmc_pkg::*;

	mode_t       cur_mode_q;
	logic [15:0] last_x_q;
	logic [15:0] last_y_q;
	logic [7:0]  pinch_cnt_q;
	logic [15:0] idle_ms_q;
	logic [15:0] mode_ms_q;

	logic [16:0] idle_sum;
	logic [16:0] mode_sum;
	logic [15:0] idle_sat;
	logic [15:0] mode_sat;
	logic        moved;
	logic        no_track;
	logic        track_run;
	logic        click;
	logic        pinch_eval;
	logic        pinch;
	logic [7:0]  pinch_next;
	logic        pinch_hit;
	logic        matched;
	logic        changed;
	mode_t       next_mode;

	always_comb begin
		idle_sum = {1'b0, idle_ms_q} + {9'd0, frame_s1.elapsed_ms};
		mode_sum = {1'b0, mode_ms_q} + {9'd0, frame_s1.elapsed_ms};
		idle_sat = idle_sum[16] ? 16'hFFFF : idle_sum[15:0];
		mode_sat = mode_sum[16] ? 16'hFFFF : mode_sum[15:0];
		moved = (frame_s1.pointer_x != last_x_q) || (frame_s1.pointer_y != last_y_q);

		no_track = !cfg.mouse_only && !frame_s1.markers_ok;
		track_run = !frame_s1.key_down && !cfg.mouse_only && frame_s1.markers_ok
			&& ((cur_mode_q == MODE_CURSOR_MOVE) || (cur_mode_q == MODE_MOUSE_MOVE));
		click = track_run && click_hit;

		pinch_eval = !frame_s1.key_down && !cfg.mouse_only && frame_s1.markers_ok && !click;
		pinch = frame_s1.finger_gap < cfg.pinch_gap_limit;
		if (!pinch) begin
			pinch_next = '0;
		end else if (pinch_cnt_q == 8'hFF) begin
			pinch_next = pinch_cnt_q;
		end else begin
			pinch_next = pinch_cnt_q + 1'b1;
		end
		pinch_hit = pinch_eval && pinch && (pinch_next >= cfg.pinch_frames);

		matched = 1'b1;
		next_mode = cur_mode_q;
		if (frame_s1.key_down) begin
			next_mode = MODE_KEYBOARD;
		end else if (no_track) begin
			next_mode = MODE_IDLE;
		end else if (click) begin
			next_mode = MODE_CURSOR_CLICK;
		end else if (pinch_hit) begin
			next_mode = MODE_CURSOR_MOVE;
		end else if (frame_s1.button_down) begin
			next_mode = MODE_MOUSE_CLICK;
		end else if (moved) begin
			next_mode = MODE_MOUSE_MOVE;
		end else if (idle_sat > cfg.idle_limit_ms) begin
			next_mode = MODE_IDLE;
		end else if (cur_mode_q == MODE_CURSOR_CLICK) begin
			// click lasts a single frame
			next_mode = MODE_IDLE;
		end else begin
			matched = 1'b0;
		end
		changed = matched && (next_mode != cur_mode_q);

		win_ctl.update = advance && track_run;
		win_ctl.height = frame_s1.tip_height;

		result_d.mode = changed ? next_mode : cur_mode_q;
		result_d.mode_changed = changed;
		result_d.click_pulse = click;
		result_d.left_mode = changed ? cur_mode_q : MODE_IDLE;
		result_d.left_mode_ms = changed ? mode_sat : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q <= MODE_IDLE;
			last_x_q <= '0;
			last_y_q <= '0;
			pinch_cnt_q <= '0;
			idle_ms_q <= '0;
			mode_ms_q <= '0;
		end else if (advance) begin
			last_x_q <= frame_s1.pointer_x;
			last_y_q <= frame_s1.pointer_y;
			if (pinch_eval) begin
				pinch_cnt_q <= pinch_next;
			end
			idle_ms_q <= matched ? 16'd0 : idle_sat;
			mode_ms_q <= changed ? 16'd0 : mode_sat;
			if (changed) begin
				cur_mode_q <= next_mode;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/gesture_mode_classifier.sv -----
// channel   | direction | handshake                   | payload
// frame     | in        | frame_valid / frame_ready   | frame (gmc_pkg::frame_t)
// result    | out       | result_valid / result_ready | result (gmc_pkg::result_t)
// config    | in        | cfg_we                      | cfg_idx, cfg_data
//
// one frame per cycle sustained unless the result stalls; result_valid rises once the frame
// register and then the result register have taken it; a stall can hold it between the two
// throughput set by the single classify stage between the frame register and result register
// arst_n clears mode, counters, click window state and loads the configuration defaults
// a stalled result holds in the result register; the frame register keeps taking requests
// until both it and the result register are full
`default_nettype none
module gesture_mode_classifier #(
	parameter int WINDOW_LEN = gmc_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             frame_valid,
	output logic                                  frame_ready,
	input  wire gmc_pkg::frame_t                  frame,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output gmc_pkg::result_t                      result,
	input  wire logic                             cfg_we,
	input  wire logic [gmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [gmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gmc_pkg::*;

	// configuration registers
	cfg_t     cfg_q;

	// input stage
	logic     valid_s1;
	frame_t   frame_s1;

	// result register
	logic     res_valid_q;
	result_t  res_q;

	logic     advance;
	logic     click_hit;
	win_ctl_t win_ctl;
	result_t  result_d;

	// classify stage fires when it holds a frame and the result register is free or being drained
	assign advance = valid_s1 && (!res_valid_q || result_ready);
	assign frame_ready = !valid_s1 || advance;
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MOUSE_ONLY:      cfg_q.mouse_only <= cfg_data[0];
				CFG_PINCH_GAP_LIMIT: cfg_q.pinch_gap_limit <= cfg_data[15:0];
				CFG_CLICK_SUM_LIMIT: cfg_q.click_sum_limit <= $signed(cfg_data[LIMIT_W-1:0]);
				CFG_PINCH_FRAMES:    cfg_q.pinch_frames <= cfg_data[7:0];
				CFG_IDLE_LIMIT_MS:   cfg_q.idle_limit_ms <= cfg_data[15:0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// frame register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			frame_s1 <= frame;
		end
	end

	// result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result_d;
		end
	end

	// mode selection, pointer motion, pinch and timers
	gmc_mode u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.frame_s1  (frame_s1),
		.cfg       (cfg_q),
		.click_hit (click_hit),
		.win_ctl   (win_ctl),
		.result_d  (result_d)
	);

	// running sum of height second differences for the click test
	gmc_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.limit  (cfg_q.click_sum_limit),
		.hit    (click_hit)
	);

endmodule
`default_nettype wire

// ----- rtl/gmc_checker.sv -----
`default_nettype none
module gmc_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             result_valid,
	input  wire logic                             result_ready,
	input  wire gmc_pkg::result_t                 result
);
	import gmc_pkg::*;

	// a click pulse is only ever issued together with cursor click mode
	a_click_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.click_pulse |-> result.mode == MODE_CURSOR_CLICK)
		else $error("click pulse outside cursor click mode");

	// leave report is zero unless the mode changed
	a_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.mode_changed |->
			result.left_mode == MODE_IDLE && result.left_mode_ms == 16'd0)
		else $error("leave report without mode change");

	// a change really moves to a different mode
	a_left_differs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mode_changed |-> result.left_mode != result.mode)
		else $error("mode change to the same mode");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

endmodule

bind gesture_mode_classifier gmc_checker u_gmc_checker (.*);
`default_nettype wire
